FILE: hw/rtl/edn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edn_pkg
// Shared widths, datapath operation codes and controller/datapath bundles
// for the Euclidean distance block with Newton square root.
// ----------------------------------------------------------------------------
package edn_pkg;

  localparam int COORD_W = 16;  // signed Q8.8 coordinate
  localparam int DIFF_W  = 17;  // signed coordinate difference
  localparam int SUM_W   = 34;  // unsigned Q18.16 sum and root
  localparam int HALF_W  = 17;  // multiplier operand slice
  localparam int PP_W    = SUM_W + HALF_W;   // partial product
  localparam int PROD_W  = 70;  // x*x + s*2^16
  localparam int QUOT_W  = 35;  // quotient bits developed per division
  localparam int FRAC_W  = 16;  // shift of s in the numerator

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_INIT,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD_S,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic kind_2d;
    logic x_zero;
  } stat_t;

endpackage

FILE: hw/rtl/euclidean_distance_newton_sqrt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance_newton_sqrt_top
// Distance between two Q8.8 points: sum of squared differences in Q18.16
// and its square root from NEWTON_STEPS truncating Newton steps (none for a zero sum).
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request: kind (0 = 3D,
//   1 = 2D with z ignored) and the coordinates of points a and b. The output
//   channel (out_valid/out_ready) returns square_sum and distance, both
//   unsigned Q18.16.
//   One request is worked on at a time. A 3D request takes three squaring
//   passes and a 2D request two; a zero sum then finishes with no Newton
//   step. Each Newton step multiplies in two halves, adds the shifted sum
//   and runs the radix-2 restoring divider; the next request is taken in
//   the cycle after the result is registered.
//   The result sits in an output register; while it waits for out_ready the
//   next request is accepted and computed, and that one holds in the
//   finish state until the output register is free.
//   Synchronous reset returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module euclidean_distance_newton_sqrt_top #(
  parameter int NEWTON_STEPS = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [edn_pkg::COORD_W-1:0]  ax,
  input  logic signed [edn_pkg::COORD_W-1:0]  ay,
  input  logic signed [edn_pkg::COORD_W-1:0]  az,
  input  logic signed [edn_pkg::COORD_W-1:0]  bx,
  input  logic signed [edn_pkg::COORD_W-1:0]  by,
  input  logic signed [edn_pkg::COORD_W-1:0]  bz,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [edn_pkg::SUM_W-1:0]    square_sum,
  output logic        [edn_pkg::SUM_W-1:0]    distance
);
  import edn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  edn_ctrl #(
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  edn_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .kind       (kind),
    .ax         (ax),
    .ay         (ay),
    .az         (az),
    .bx         (bx),
    .by         (by),
    .bz         (bz),
    .square_sum (square_sum),
    .distance   (distance)
  );

endmodule

FILE: hw/rtl/edn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edn_datapath
// Difference squaring, split x*x multiply, numerator build and a radix-2
// restoring divider for the Newton steps, plus the result registers.
// ----------------------------------------------------------------------------
module edn_datapath (
  input  logic                                clk,
  input  edn_pkg::cmd_t                       cmd,
  output edn_pkg::stat_t                      stat,
  input  logic                                kind,
  input  logic signed [edn_pkg::COORD_W-1:0]  ax,
  input  logic signed [edn_pkg::COORD_W-1:0]  ay,
  input  logic signed [edn_pkg::COORD_W-1:0]  az,
  input  logic signed [edn_pkg::COORD_W-1:0]  bx,
  input  logic signed [edn_pkg::COORD_W-1:0]  by,
  input  logic signed [edn_pkg::COORD_W-1:0]  bz,
  output logic        [edn_pkg::SUM_W-1:0]    square_sum,
  output logic        [edn_pkg::SUM_W-1:0]    distance
);
  import edn_pkg::*;

  logic                     kind_r;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic [SUM_W-1:0]         s;
  logic [SUM_W-1:0]         x;
  logic [PROD_W-1:0]        prod;
  logic [QUOT_W-1:0]        rem;
  logic [QUOT_W-1:0]        quot;

  logic signed [DIFF_W-1:0] dsel;
  logic [DIFF_W-1:0]        mag;
  logic [2*DIFF_W-1:0]      sq;
  logic [HALF_W-1:0]        mul_op;
  logic [PP_W-1:0]          pp;
  logic [QUOT_W:0]          trial;
  logic [QUOT_W:0]          dvsr;
  logic [QUOT_W:0]          trial_sub;
  logic                     ge;

  always_comb begin
    case (cmd.axis)
      AXIS_X:  dsel = dx;
      AXIS_Y:  dsel = dy;
      AXIS_Z:  dsel = dz;
      default: dsel = '0;
    endcase
    mag = dsel[DIFF_W-1] ? DIFF_W'(-dsel) : DIFF_W'(dsel);
    sq  = {{DIFF_W{1'b0}}, mag} * {{DIFF_W{1'b0}}, mag};

    mul_op = (cmd.op == OP_MUL_HI) ? x[SUM_W-1:HALF_W] : x[HALF_W-1:0];
    pp     = {{HALF_W{1'b0}}, x} * {{SUM_W{1'b0}}, mul_op};

    // divisor is 2x; bring the next dividend bit in from the top of quot
    trial     = {rem, quot[QUOT_W-1]};
    dvsr      = {1'b0, x, 1'b0};
    ge        = (trial >= dvsr);
    trial_sub = trial - dvsr;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r <= kind;
        dx     <= DIFF_W'(bx) - DIFF_W'(ax);
        dy     <= DIFF_W'(by) - DIFF_W'(ay);
        dz     <= DIFF_W'(bz) - DIFF_W'(az);
        s      <= '0;
      end
      OP_SQ: begin
        s <= s + sq;
      end
      OP_INIT: begin
        x <= s;
      end
      OP_MUL_LO: begin
        prod <= {{(PROD_W-PP_W){1'b0}}, pp};
      end
      OP_MUL_HI: begin
        prod <= prod + {{(PROD_W-PP_W-HALF_W){1'b0}}, pp, {HALF_W{1'b0}}};
      end
      OP_ADD_S: begin
        prod <= prod + {{(PROD_W-SUM_W-FRAC_W){1'b0}}, s, {FRAC_W{1'b0}}};
      end
      OP_DIV_INIT: begin
        // quotient stays below 2^QUOT_W, so the upper part is already < 2x
        rem  <= prod[PROD_W-1:QUOT_W];
        quot <= prod[QUOT_W-1:0];
      end
      OP_DIV_STEP: begin
        rem  <= ge ? trial_sub[QUOT_W-1:0] : trial[QUOT_W-1:0];
        quot <= {quot[QUOT_W-2:0], ge};
      end
      OP_DIV_DONE: begin
        x <= quot[SUM_W-1:0];
      end
      OP_OUT: begin
        square_sum <= s;
        distance   <= x;
      end
      default: begin
      end
    endcase
  end

  assign stat.kind_2d = kind_r;
  assign stat.x_zero  = (x == '0);

endmodule

FILE: hw/rtl/edn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edn_ctrl
// Sequencer for the distance block: request handshake, squaring passes,
// Newton step loop, divider bit count and the result handshake.
// ----------------------------------------------------------------------------
module edn_ctrl #(
  parameter int NEWTON_STEPS = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output edn_pkg::cmd_t   cmd,
  input  edn_pkg::stat_t  stat
);
  import edn_pkg::*;

  localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
  localparam int BIT_W  = $clog2(QUOT_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_INIT,
    S_CHK,
    S_MUL_LO,
    S_MUL_HI,
    S_ADD_S,
    S_DIV_INIT,
    S_DIV,
    S_DIV_DONE,
    S_FINISH
  } state_t;

  state_t            state;
  logic [1:0]        axis;
  logic [STEP_W-1:0] step;
  logic [BIT_W-1:0]  bit_cnt;
  logic [1:0]        last_axis;
  logic              out_free;

  assign last_axis = stat.kind_2d ? AXIS_Y : AXIS_Z;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd.axis = axis;
    case (state)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NOP;
      S_SQ:       cmd.op = OP_SQ;
      S_INIT:     cmd.op = OP_INIT;
      S_MUL_LO:   cmd.op = OP_MUL_LO;
      S_MUL_HI:   cmd.op = OP_MUL_HI;
      S_ADD_S:    cmd.op = OP_ADD_S;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV:      cmd.op = OP_DIV_STEP;
      S_DIV_DONE: cmd.op = OP_DIV_DONE;
      S_FINISH:   cmd.op = out_free ? OP_OUT : OP_NOP;
      default:    cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      axis      <= AXIS_X;
      step      <= '0;
      bit_cnt   <= '0;
    end else begin
      // in the finish state a taken result is replaced, not dropped
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= AXIS_X;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          axis <= axis + 2'd1;
          if (axis == last_axis) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          step  <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          // a zero estimate means a zero sum: the root is zero, stop
          if (stat.x_zero || step == STEP_W'(NEWTON_STEPS)) begin
            state <= S_FINISH;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO:   state <= S_MUL_HI;
        S_MUL_HI:   state <= S_ADD_S;
        S_ADD_S:    state <= S_DIV_INIT;
        S_DIV_INIT: begin
          bit_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(QUOT_W - 1)) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          step  <= step + 1'b1;
          state <= S_CHK;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_euclidean_distance_newton_sqrt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euclidean_distance_newton_sqrt_top
// Drives point pairs into the distance block and compares every result with
// a bit-exact prediction of the Q18.16 sum of squares and the truncating
// five-step Newton root. Traffic covers corner coordinates, random pairs
// with random stalls on both channels, a long output hold-off and an
// unbroken stream.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_newton_sqrt_top;
  import edn_pkg::*;

  localparam int NEWTON_STEPS     = 5;
  localparam int LONG_HOLD_CYCLES = 1000;
  localparam int DRAIN_CYCLES     = 250;
  localparam int RANDOM_ITEMS     = 640;
  localparam int PRESSURE_ITEMS   = 6;
  localparam int STEADY_ITEMS     = 140;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bz;
  } point_pair_t;

  typedef struct packed {
    logic [SUM_W-1:0] square_sum;
    logic [SUM_W-1:0] distance;
  } distance_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       kind;
  logic signed [COORD_W-1:0]  ax;
  logic signed [COORD_W-1:0]  ay;
  logic signed [COORD_W-1:0]  az;
  logic signed [COORD_W-1:0]  bx;
  logic signed [COORD_W-1:0]  by;
  logic signed [COORD_W-1:0]  bz;
  logic                       out_valid;
  logic                       out_ready;
  logic        [SUM_W-1:0]    square_sum;
  logic        [SUM_W-1:0]    distance;

  distance_t expected_distances[$];
  distance_t oldest_distance;
  int        error_count;
  int        requests_sent;
  int        requests_2d;
  int        zero_sums;
  int        results_checked;
  bit        idle_en;
  bit        long_hold_pending;

  euclidean_distance_newton_sqrt_top #(
    .NEWTON_STEPS(NEWTON_STEPS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .ax        (ax),
    .ay        (ay),
    .az        (az),
    .bx        (bx),
    .by        (by),
    .bz        (bz),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .square_sum(square_sum),
    .distance  (distance)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint unsigned axis_square(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    longint d;
    d = longint'($signed(b)) - longint'($signed(a));
    return d * d;
  endfunction

  function automatic distance_t predict_distance(point_pair_t p);
    logic [127:0] s;
    logic [127:0] x;
    distance_t    r;
    s = axis_square(p.ax, p.bx) + axis_square(p.ay, p.by);
    if (!p.kind)
      s += axis_square(p.az, p.bz);
    // x' = (x*x + s) / (2x) in Q18.16, truncated; a zero sum stays zero
    x = s;
    for (int i = 0; i < NEWTON_STEPS; i++)
      if (x != 0)
        x = (x * x + (s << FRAC_W)) / (x << 1);
    r.square_sum = s[SUM_W-1:0];
    r.distance   = x[SUM_W-1:0];
    return r;
  endfunction

  function automatic point_pair_t pair_of(bit k, int a0, int a1, int a2,
                                          int b0, int b1, int b2);
    point_pair_t p;
    p.kind = k;
    p.ax = a0[COORD_W-1:0];
    p.ay = a1[COORD_W-1:0];
    p.az = a2[COORD_W-1:0];
    p.bx = b0[COORD_W-1:0];
    p.by = b1[COORD_W-1:0];
    p.bz = b2[COORD_W-1:0];
    return p;
  endfunction

  function automatic point_pair_t random_pair();
    logic [COORD_W-1:0] corners[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    point_pair_t        p;
    int                 style;
    p.kind = 1'($urandom_range(0, 1));
    p.ax = COORD_W'($urandom);
    p.ay = COORD_W'($urandom);
    p.az = COORD_W'($urandom);
    p.bx = COORD_W'($urandom);
    p.by = COORD_W'($urandom);
    p.bz = COORD_W'($urandom);
    style = $urandom_range(0, 9);
    if (style == 5 || style == 6) begin
      // near points: small sums, including ones below one
      p.bx = p.ax + COORD_W'($urandom_range(0, 600) - 300);
      p.by = p.ay + COORD_W'($urandom_range(0, 600) - 300);
      p.bz = p.az + COORD_W'($urandom_range(0, 600) - 300);
    end else if (style == 7) begin
      p.bx = p.ax;
      p.by = p.ay;
      if ($urandom_range(0, 1) == 0)
        p.bz = p.az;
    end else if (style == 8) begin
      p.ax = corners[$urandom_range(0, 3)];
      p.ay = corners[$urandom_range(0, 3)];
      p.az = corners[$urandom_range(0, 3)];
      p.bx = corners[$urandom_range(0, 3)];
      p.by = corners[$urandom_range(0, 3)];
      p.bz = corners[$urandom_range(0, 3)];
    end else if (style == 9) begin
      p.by = p.ay;
      p.bz = p.az;
    end
    return p;
  endfunction

  task automatic send_request(point_pair_t p);
    distance_t want;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= p.kind;
    ax       <= p.ax;
    ay       <= p.ay;
    az       <= p.az;
    bx       <= p.bx;
    by       <= p.by;
    bz       <= p.bz;
    do @(posedge clk); while (!in_ready);
    want = predict_distance(p);
    expected_distances.push_back(want);
    requests_sent++;
    if (p.kind)
      requests_2d++;
    if (want.square_sum == 0)
      zero_sums++;
  endtask

  task automatic test_directed();
    send_request(pair_of(0, 0, 0, 0, 0, 0, 0));
    send_request(pair_of(1, 100, -200, -32768, 100, -200, 32767));
    send_request(pair_of(0, 0, 0, 0, 1, 0, 0));
    send_request(pair_of(0, 0, 0, 0, 255, 0, 0));
    send_request(pair_of(0, 0, 0, 0, 256, 0, 0));
    send_request(pair_of(0, -32768, -32768, -32768, 32767, 32767, 32767));
    send_request(pair_of(0, 32767, 32767, 32767, -32768, -32768, -32768));
    send_request(pair_of(1, -32768, 32767, 0, 32767, -32768, -1));
    send_request(pair_of(1, -1, -1, -1, 0, 0, 0));
    send_request(pair_of(0, -1, -1, -1, -1, -1, -1));
    send_request(pair_of(0, 0, 0, -32768, 0, 0, 32767));
    send_request(pair_of(1, 0, 0, -32768, 0, 0, 32767));
    send_request(pair_of(0, 256, 512, 768, -256, -512, -768));
    send_request(pair_of(0, 1, 1, 1, 0, 0, 0));
    send_request(pair_of(1, 0, 0, 0, 768, 1024, 0));
    send_request(pair_of(0, 21845, -21846, 21845, -21846, 21845, -21846));
  endtask

  task automatic test_random_traffic();
    idle_en = 1'b1;
    repeat (RANDOM_ITEMS) send_request(random_pair());
  endtask

  // hold the output long enough that the result register and the finish
  // state both fill and the input stalls
  task automatic test_output_backpressure();
    long_hold_pending = 1'b1;
    repeat (PRESSURE_ITEMS) send_request(random_pair());
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    repeat (STEADY_ITEMS) send_request(random_pair());
  endtask

  // output side flow control
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_distances.size() == 0) begin
        $error("unexpected result: square_sum %0d distance %0d", square_sum, distance);
        error_count++;
      end else begin
        oldest_distance = expected_distances.pop_front();
        results_checked++;
        if (square_sum !== oldest_distance.square_sum) begin
          $error("square_sum mismatch: expected %0d, actual %0d",
                 oldest_distance.square_sum, square_sum);
          error_count++;
        end
        if (distance !== oldest_distance.distance) begin
          $error("distance mismatch: expected %0d, actual %0d",
                 oldest_distance.distance, distance);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    kind              = 1'b0;
    ax                = '0;
    ay                = '0;
    az                = '0;
    bx                = '0;
    by                = '0;
    bz                = '0;
    idle_en           = 1'b1;
    long_hold_pending = 1'b0;
    error_count       = 0;
    requests_sent     = 0;
    requests_2d       = 0;
    zero_sums         = 0;
    results_checked   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();

    in_valid <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d point pairs (%0d 2D, %0d with zero sum); %0d results compared.",
             requests_sent, requests_2d, zero_sums, results_checked);
    $display("Traffic ran with random stalls, a long output hold-off and a gap-free stream.");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
